FILE: rtl/gbse_pkg.sv
// ----------------------------------------------------------------------------
// Golomb block size estimator package
// Shared constants, types and a helper function.
// ----------------------------------------------------------------------------
package gbse_pkg;

    localparam int BLOCK_MAX   = 64;
    localparam int SAMPLE_BITS = 14;
    localparam int IDX_W       = $clog2(BLOCK_MAX);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int CNT_W       = IDX_W + 1;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int SAMP_W      = SAMPLE_BITS + 1;
    localparam int SUM_W       = SAMP_W + IDX_W + 1;
    localparam int CODED_W     = 21;
    localparam int SENT_W      = 10;
    localparam int SIZE_W      = 7;
    localparam int MODE_W      = 2;
    localparam int QLEN_W      = MAG_W + 1;
    localparam int RLEN_W      = 5;

    localparam logic [SIZE_W-1:0] REG_BLOCK_SIZE   = 7'd0;
    localparam logic [SIZE_W-1:0] REG_DIVISOR_MODE = 7'd1;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_MEAN = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_MAX  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MEAN,
        BK_READ,
        BK_DIV,
        BK_TOTAL,
        BK_OUT
    } bk_state_t;

    // Block-end summary handed from front to back. The bank says which half
    // of the sample store holds the block.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [MAG_W-1:0] min_mag;
        logic [MAG_W-1:0] max_mag;
        mode_t            mode;
        logic             bank;
    } blk_desc_t;

    // Sign-plus-magnitude length: 1 + bit length, 2 for zero.
    function automatic logic [RLEN_W-1:0] sm_length(input logic [MAG_W-1:0] mag);
        logic [RLEN_W-1:0] n;
        n = RLEN_W'(1);
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag[i])
            begin
                n = RLEN_W'(i + 2);
            end
        end
        if (mag == '0)
        begin
            n = RLEN_W'(2);
        end
        return n;
    endfunction

endpackage

FILE: rtl/golomb_block_size_estimator_core.sv
// ----------------------------------------------------------------------------
// Golomb block size estimator core
// Collects signed samples into blocks and estimates their Golomb-coded size.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_axis  | in        | tdata[14:0] sample
//  m_axis  | out       | tdata: coded_bits[20:0], sent_bits[30:21], raw_flag[31],
//          |           |        divisor[46:32]
//  cfg     | in        | index 0 block_size, index 1 divisor_mode
//
// The front end takes samples while it gathers a block into one half of a
// two-bank store. At the block's end the back end divides the rounded mean
// and then each stored sample by the divisor in a shared 22-step restoring
// divider. The front end gathers the next block in the other bank meanwhile;
// it stalls only when a finished block waits. Reset clears all control state;
// a block_size write drops the partial block.
module golomb_block_size_estimator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample[14:0], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // coded_bits, sent_bits, raw_flag, divisor
);
    import gbse_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    mode_t             mode_reg;
    logic              cfg_clear;
    logic              dq_valid, dq_ready;
    blk_desc_t         dq;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SAMP_W-1:0] wr_data;
    logic [CODED_W-1:0] coded;
    logic [SENT_W-1:0] sent;
    logic              rawf;
    logic [SAMP_W-1:0] div_o;

    assign cfg_clear = cfg_we && (cfg_index == REG_BLOCK_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(2);
            mode_reg <= MODE_NONE;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BLOCK_SIZE)
                size_reg <= cfg_data;
            else if (cfg_index == REG_DIVISOR_MODE)
                mode_reg <= mode_t'(cfg_data[MODE_W-1:0]);
        end
    end

    gbse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_clear  (cfg_clear),
        .block_size (size_reg),
        .mode       (mode_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[SAMP_W-1:0]),
        .desc_valid (dq_valid),
        .desc_ready (dq_ready),
        .desc       (dq),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    gbse_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc_valid  (dq_valid),
        .desc_ready  (dq_ready),
        .desc        (dq),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_coded   (coded),
        .out_sent    (sent),
        .out_raw     (rawf),
        .out_divisor (div_o)
    );

    assign m_axis_tdata = {1'b0, div_o, rawf, sent, coded};

endmodule

FILE: rtl/gbse_front.sv
// ----------------------------------------------------------------------------
// Golomb estimator front end
// Accepts samples, saturates them, stores them and keeps block statistics.
// ----------------------------------------------------------------------------
module gbse_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_clear,
    input  logic [gbse_pkg::SIZE_W-1:0]    block_size,
    input  gbse_pkg::mode_t                mode,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [gbse_pkg::SAMP_W-1:0]    in_sample,
    output logic                           desc_valid,
    input  logic                           desc_ready,
    output gbse_pkg::blk_desc_t            desc,
    output logic                           wr_en,
    output logic [gbse_pkg::ADDR_W-1:0]    wr_addr,
    output logic [gbse_pkg::SAMP_W-1:0]    wr_data
);
    import gbse_pkg::*;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0] min_reg, min_next, max_reg, max_next;
    logic             dv_reg, dv_next;
    logic             bank_reg, bank_next;
    blk_desc_t        desc_reg, desc_next;
    logic [CNT_W-1:0] eff_n;
    logic [MAG_W-1:0] mag;
    logic [SAMP_W-1:0] xs;
    logic             take, last;

    always_comb
    begin
        if (block_size < SIZE_W'(2))
            eff_n = CNT_W'(2);
        else if (block_size > SIZE_W'(BLOCK_MAX))
            eff_n = CNT_W'(BLOCK_MAX);
        else
            eff_n = CNT_W'(block_size);
        // The most negative pattern saturates to the largest magnitude.
        if (in_sample[SAMP_W-1])
            mag = (in_sample == {1'b1, {MAG_W{1'b0}}}) ? {MAG_W{1'b1}}
                                                        : MAG_W'(-in_sample);
        else
            mag = in_sample[MAG_W-1:0];
        xs = in_sample[SAMP_W-1] ? -{1'b0, mag} : {1'b0, mag};
    end

    // A full block waits here until the back end has finished the last one.
    // Blocks alternate between the two halves of the store, so the next
    // block fills one half while the back end sweeps the other.
    assign in_ready = !dv_reg;
    assign take     = in_valid && in_ready;
    assign last     = (fill_reg + CNT_W'(1)) >= eff_n;
    assign wr_en    = take;
    assign wr_addr  = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wr_data  = xs;

    always_comb
    begin
        fill_next = fill_reg;
        sum_next  = sum_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        bank_next = bank_reg;
        dv_next   = dv_reg && !desc_ready;
        desc_next = desc_reg;
        if (take)
        begin
            if (last)
            begin
                dv_next        = 1'b1;
                desc_next.count = fill_reg + CNT_W'(1);
                desc_next.sum   = sum_reg + {{(SUM_W-SAMP_W){xs[SAMP_W-1]}}, xs};
                desc_next.min_mag = (mag < min_reg) ? mag : min_reg;
                desc_next.max_mag = (mag > max_reg) ? mag : max_reg;
                desc_next.mode  = mode;
                desc_next.bank  = bank_reg;
                bank_next = !bank_reg;
                fill_next = '0;
                sum_next  = '0;
                min_next  = '1;
                max_next  = '0;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
                sum_next  = sum_reg + {{(SUM_W-SAMP_W){xs[SAMP_W-1]}}, xs};
                min_next  = (mag < min_reg) ? mag : min_reg;
                max_next  = (mag > max_reg) ? mag : max_reg;
            end
        end
        if (cfg_clear)
        begin
            fill_next = '0;
            sum_next  = '0;
            min_next  = '1;
            max_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sum_reg  <= '0;
            min_reg  <= '1;
            max_reg  <= '0;
            bank_reg <= 1'b0;
            dv_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            min_reg  <= min_next;
            max_reg  <= max_next;
            bank_reg <= bank_next;
            dv_reg   <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign desc_valid = dv_reg;
    assign desc       = desc_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(BLOCK_MAX)) else $error("fill count out of range");
    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> !take) else $error("sample taken while block pending");
    a_last_raises: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last && !cfg_clear) |=> dv_reg) else $error("block end lost");

endmodule

FILE: rtl/gbse_divider.sv
// ----------------------------------------------------------------------------
// Golomb estimator divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbse_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gbse_pkg::SUM_W-1:0]   dividend,
    input  logic [gbse_pkg::SUM_W-1:0]   divisor,
    output logic                         done,
    output logic [gbse_pkg::SUM_W-1:0]   quotient,
    output logic [gbse_pkg::SUM_W-1:0]   remainder
);
    import gbse_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [SUM_W:0]    trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[SUM_W-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SUM_W])
            begin
                r_next = trial[SUM_W-1:0];
                q_next = {q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[SUM_W-2:0], q_reg[SUM_W-1]};
                q_next = {q_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = !busy_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: rtl/gbse_back.sv
// ----------------------------------------------------------------------------
// Golomb estimator back end
// Picks the divisor, sweeps the stored block and forms the bit counts.
// ----------------------------------------------------------------------------
module gbse_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          desc_valid,
    output logic                          desc_ready,
    input  gbse_pkg::blk_desc_t           desc,
    input  logic                          wr_en,
    input  logic [gbse_pkg::ADDR_W-1:0]   wr_addr,
    input  logic [gbse_pkg::SAMP_W-1:0]   wr_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gbse_pkg::CODED_W-1:0]  out_coded,
    output logic [gbse_pkg::SENT_W-1:0]   out_sent,
    output logic                          out_raw,
    output logic [gbse_pkg::SAMP_W-1:0]   out_divisor
);
    import gbse_pkg::*;

    logic [SAMP_W-1:0] mem [2*BLOCK_MAX];
    logic [SAMP_W-1:0] rd_data;
    logic [ADDR_W-1:0] rd_addr;

    bk_state_t         st_reg, st_next;
    blk_desc_t         d_reg, d_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [MAG_W-1:0]  bmag_reg, bmag_next;
    logic              bneg_reg, bneg_next;
    logic [QLEN_W-1:0] ql_reg, ql_next;
    logic [RLEN_W-1:0] rl_reg, rl_next;
    logic [MAG_W-1:0]  smag_reg, smag_next;
    logic              ov_reg, ov_next;
    logic [CODED_W-1:0] coded_reg, coded_next;
    logic [SENT_W-1:0] sent_reg, sent_next;
    logic              raw_reg, raw_next;
    logic [SAMP_W-1:0] bout_reg, bout_next;

    logic              dv_start, dv_done;
    logic [SUM_W-1:0]  dv_num, dv_den, dv_q, dv_r;
    logic [SUM_W-1:0]  abs_sum;
    logic [CODED_W-1:0] prod_q, prod_r, rawbits, coded_c;
    logic [QLEN_W-1:0] ul;
    logic [RLEN_W-1:0] rlc;
    logic [MAG_W-1:0]  rmag;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    gbse_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (dv_num),
        .divisor   (dv_den),
        .done      (dv_done),
        .quotient  (dv_q),
        .remainder (dv_r)
    );

    // The mean division starts in the cycle the block is taken, so its
    // operands come straight from the incoming summary.
    assign abs_sum = desc.sum[SUM_W-1] ? -desc.sum : desc.sum;
    assign rd_addr = {d_reg.bank, idx_reg[IDX_W-1:0]};
    assign ul      = QLEN_W'(dv_q) + QLEN_W'(1);
    assign rmag    = (bmag_reg == '0) ? smag_reg : dv_r[MAG_W-1:0];
    assign rlc     = sm_length(rmag);
    assign prod_q  = CODED_W'(d_reg.count) * CODED_W'(ql_reg);
    assign prod_r  = CODED_W'(d_reg.count) * CODED_W'(rl_reg);
    assign rawbits = CODED_W'(d_reg.count) * CODED_W'(SAMPLE_BITS);
    assign coded_c = CODED_W'(sm_length(bmag_reg)) + prod_q + prod_r;

    // Next state.
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:  if (desc_valid) st_next = BK_MEAN;
            BK_MEAN:  if (dv_done && !ov_reg) st_next = BK_READ;
            BK_READ:  st_next = BK_DIV;
            BK_DIV:
            begin
                if (dv_done && !ov_reg)
                    st_next = (idx_reg == d_reg.count) ? BK_TOTAL : BK_READ;
            end
            BK_TOTAL: st_next = BK_OUT;
            BK_OUT:   if (out_ready) st_next = BK_IDLE;
            default:  st_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        d_next     = d_reg;
        idx_next   = idx_reg;
        bmag_next  = bmag_reg;
        bneg_next  = bneg_reg;
        ql_next    = ql_reg;
        rl_next    = rl_reg;
        ov_next    = 1'b0;
        coded_next = coded_reg;
        sent_next  = sent_reg;
        raw_next   = raw_reg;
        bout_next  = bout_reg;
        dv_start   = 1'b0;
        dv_num     = {abs_sum[SUM_W-2:0], 1'b0} + SUM_W'(desc.count);
        dv_den     = SUM_W'({desc.count, 1'b0});
        desc_ready = 1'b0;
        out_valid  = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                desc_ready = 1'b1;
                if (desc_valid)
                begin
                    d_next   = desc;
                    idx_next = '0;
                    ql_next  = '0;
                    rl_next  = '0;
                    dv_start = 1'b1;
                    ov_next  = 1'b1;
                end
            end
            BK_MEAN:
            begin
                if (dv_done && !ov_reg)
                begin
                    case (d_reg.mode)
                        MODE_MEAN:
                        begin
                            bmag_next = dv_q[MAG_W-1:0];
                            bneg_next = d_reg.sum[SUM_W-1];
                        end
                        MODE_MIN:
                        begin
                            bmag_next = d_reg.min_mag;
                            bneg_next = 1'b0;
                        end
                        MODE_MAX:
                        begin
                            bmag_next = d_reg.max_mag;
                            bneg_next = 1'b0;
                        end
                        default:
                        begin
                            bmag_next = '0;
                            bneg_next = 1'b0;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                idx_next = idx_reg + CNT_W'(1);
            end
            BK_DIV:
            begin
                if (ov_reg || !dv_done)
                begin
                    ov_next = !ov_reg ? 1'b0 : 1'b0;
                end
                else
                begin
                    if (ul > ql_next && bmag_reg != '0)
                        ql_next = ul;
                    if (bmag_reg == '0 && ql_reg == '0)
                        ql_next = QLEN_W'(1);
                    if (rlc > rl_reg)
                        rl_next = rlc;
                end
            end
            BK_TOTAL:
            begin
                coded_next = coded_c;
                raw_next   = coded_c > rawbits;
                sent_next  = SENT_W'((coded_c > rawbits) ? rawbits : coded_c);
                bout_next  = bneg_reg ? -{1'b0, bmag_reg} : {1'b0, bmag_reg};
            end
            BK_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        // Launch the division for the sample just read from the store.
        if (st_reg == BK_READ)
        begin
            dv_start  = 1'b1;
            ov_next   = 1'b1;
            dv_num    = SUM_W'(smag_next);
            dv_den    = SUM_W'(bmag_reg);
        end
    end

    // Stored samples are saturated, so the magnitude fits the field.
    always_comb
    begin
        smag_next = rd_data[SAMP_W-1] ? MAG_W'(-rd_data) : rd_data[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        idx_reg   <= idx_next;
        bmag_reg  <= bmag_next;
        bneg_reg  <= bneg_next;
        ql_reg    <= ql_next;
        rl_reg    <= rl_next;
        // The magnitude is held for the whole division of its sample.
        if (st_reg == BK_READ)
            smag_reg <= smag_next;
        coded_reg <= coded_next;
        sent_reg  <= sent_next;
        raw_reg   <= raw_next;
        bout_reg  <= bout_next;
    end

    assign out_coded   = coded_reg;
    assign out_sent    = sent_reg;
    assign out_raw     = raw_reg;
    assign out_divisor = bout_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_DIV) |-> (idx_reg <= d_reg.count)) else $error("sweep overrun");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        desc_ready |-> (st_reg == BK_IDLE)) else $error("block taken while busy");

endmodule
